[design/capw_pkg.sv]
// shared constants, register codes and byte helpers for the pixel writer
package capw_pkg;

   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned WORD_W  = 24;
   localparam int unsigned DIM_W   = 9;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned OADDR_W = 16;
   localparam int unsigned CSR_IDX_W = 3;
   // y * stride + x with both operands below 512
   localparam int unsigned LIN_W   = 2 * DIM_W + 1;
   localparam int unsigned SUM_W   = 2 * CHAN_W;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FB_ENABLE      = 3'd0,
      CSR_FRAME_WIDTH    = 3'd1,
      CSR_FRAME_HEIGHT   = 3'd2,
      CSR_LINE_STRIDE    = 3'd3,
      CSR_BYTE_ORDER_BGR = 3'd4
   } csr_index_type;

   // swaps low and high byte unless the store is in bgr order;
   // the same mapping serves both pack and unpack
   function automatic logic [WORD_W-1:0] swap_rb(input logic [WORD_W-1:0] w,
                                                 input logic bgr);
      if (bgr) begin
         return w;
      end
      return {w[7:0], w[15:8], w[23:16]};
   endfunction

   // exact floor(x / 255) for x below 65280
   function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] x);
      logic [SUM_W:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

[design/capw_store.sv]
// frame store: one write port, one read port with registered read data
module capw_store #(
   parameter int unsigned STORE_WORDS = 65536
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [$clog2(STORE_WORDS)-1:0]        wr_addr,
   input  logic [capw_pkg::WORD_W-1:0]           wr_data,
   input  logic                                  rd_en,
   input  logic [$clog2(STORE_WORDS)-1:0]        rd_addr,
   output logic [capw_pkg::WORD_W-1:0]           rd_data
);
   import capw_pkg::*;

   logic [WORD_W-1:0] mem [STORE_WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/capw_blend.sv]
// per-channel alpha mix: registered weighted sums, then divide by 255
module capw_blend (
   input  logic                          clock,
   input  logic                          load,
   input  logic [capw_pkg::WORD_W-1:0]   color,
   input  logic [capw_pkg::WORD_W-1:0]   old_rgb,
   input  logic [capw_pkg::CHAN_W-1:0]   alpha,
   output logic [capw_pkg::WORD_W-1:0]   mixed_rgb
);
   import capw_pkg::*;

   logic [SUM_W-1:0] sum_ff [3];
   logic [SUM_W-1:0] sum_in [3];
   logic [CHAN_W-1:0] inv_alpha;

   assign inv_alpha = CHAN_MAX - alpha;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = SUM_W'(color[i*CHAN_W +: CHAN_W]) * SUM_W'(alpha)
                   + SUM_W'(old_rgb[i*CHAN_W +: CHAN_W]) * SUM_W'(inv_alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mixed_rgb[i*CHAN_W +: CHAN_W] = div255(sum_ff[i]);
      end
   end

endmodule

[design/clipped_alpha_pixel_writer_top.sv]
// clipped alpha pixel writer: clipping, addressing and read-modify-write control
// one transaction at a time; a write steps through address and write-back before its response,
// a blend through address, store read, mix, then divide and write back; write-back waits while a held response stalls
// no new request is taken until the previous one has left write-back
// reset clears the configuration, state and response-valid registers and then sweeps the frame store to zero,
// one word per cycle across every address, with req_stall held high
module clipped_alpha_pixel_writer_top #(
   parameter int unsigned MAX_DIM     = 256,
   parameter int unsigned STORE_WORDS = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic signed [capw_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [capw_pkg::POS_W-1:0]   req_pos_y,
   input  logic [capw_pkg::WORD_W-1:0]         req_color,
   input  logic [capw_pkg::CHAN_W-1:0]         req_alpha,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_written,
   output logic [capw_pkg::OADDR_W-1:0]        rsp_word_address,
   output logic [capw_pkg::WORD_W-1:0]         rsp_stored_word,
   input  logic                                csr_wr_en,
   input  logic [capw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [capw_pkg::DIM_W-1:0]          csr_wdata
);
   import capw_pkg::*;

   localparam int unsigned AW = $clog2(STORE_WORDS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_MIX,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic             fb_enable_ff;
   logic [DIM_W-1:0] frame_width_ff;
   logic [DIM_W-1:0] frame_height_ff;
   logic [DIM_W-1:0] line_stride_ff;
   logic             byte_order_bgr_ff;

   logic              kind_ff;
   logic [POS_W-1:0]  pos_x_ff;
   logic [POS_W-1:0]  pos_y_ff;
   logic [WORD_W-1:0] color_ff;
   logic [CHAN_W-1:0] alpha_ff;

   logic          hit_ff, hit_in;
   logic [AW-1:0] addr_ff, addr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_written_ff, rsp_written_in;
   logic [OADDR_W-1:0] rsp_address_ff, rsp_address_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;

   logic [DIM_W-1:0] w_sat, h_sat, stride_sat;
   logic             in_frame;
   logic [LIN_W-1:0] lin_addr;
   logic             req_take;
   logic             slot_free;

   logic              st_wr_en;
   logic [AW-1:0]     st_wr_addr;
   logic [WORD_W-1:0] st_wr_data;
   logic              st_rd_en;
   logic [WORD_W-1:0] st_rd_data;
   logic [WORD_W-1:0] old_rgb;
   logic [WORD_W-1:0] mixed_rgb;
   logic [WORD_W-1:0] new_word;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_enable_ff      <= 1'b0;
         frame_width_ff    <= '0;
         frame_height_ff   <= '0;
         line_stride_ff    <= '0;
         byte_order_bgr_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FB_ENABLE:      fb_enable_ff      <= csr_wdata[0];
            CSR_FRAME_WIDTH:    frame_width_ff    <= csr_wdata;
            CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_wdata;
            CSR_LINE_STRIDE:    line_stride_ff    <= csr_wdata;
            CSR_BYTE_ORDER_BGR: byte_order_bgr_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // saturated values never exceed the 9-bit register, so truncation is safe
   assign w_sat      = (32'(frame_width_ff) > 32'(MAX_DIM))  ? DIM_W'(MAX_DIM) : frame_width_ff;
   assign h_sat      = (32'(frame_height_ff) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : frame_height_ff;
   assign stride_sat = (32'(line_stride_ff) > 32'(MAX_DIM))  ? DIM_W'(MAX_DIM) : line_stride_ff;

   assign in_frame = fb_enable_ff
                   && !pos_x_ff[POS_W-1] && !pos_y_ff[POS_W-1]
                   && (pos_x_ff < POS_W'(w_sat))
                   && (pos_y_ff < POS_W'(h_sat));

   assign lin_addr = LIN_W'(LIN_W'(pos_y_ff[DIM_W-1:0]) * LIN_W'(stride_sat))
                   + LIN_W'(pos_x_ff[DIM_W-1:0]);

   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign old_rgb  = swap_rb(st_rd_data, byte_order_bgr_ff);
   assign new_word = swap_rb(kind_ff ? mixed_rgb : color_ff, byte_order_bgr_ff);

   // store write: clearing sweep, or the write-back of a finished transaction
   assign st_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_DONE && slot_free && hit_ff);
   assign st_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr_ff;
   assign st_wr_data = (state_ff == ST_CLEAR) ? '0 : new_word;
   assign st_rd_en   = (state_ff == ST_READ);

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      hit_in          = hit_ff;
      addr_in         = addr_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_written_in  = rsp_written_ff;
      rsp_address_in  = rsp_address_ff;
      rsp_word_in     = rsp_word_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            hit_in  = in_frame;
            addr_in = AW'(lin_addr);
            state_in = (in_frame && kind_ff) ? ST_READ : ST_DONE;
         end
         ST_READ: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_written_in = hit_ff;
               rsp_address_in = hit_ff ? OADDR_W'(addr_ff) : '0;
               rsp_word_in    = hit_ff ? new_word : '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hit_ff         <= hit_in;
      addr_ff        <= addr_in;
      rsp_written_ff <= rsp_written_in;
      rsp_address_ff <= rsp_address_in;
      rsp_word_ff    <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff  <= req_kind;
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         color_ff <= req_color;
         alpha_ff <= req_alpha;
      end
   end

   capw_store #(
      .STORE_WORDS (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (addr_ff),
      .rd_data (st_rd_data)
   );

   capw_blend u_blend (
      .clock     (clock),
      .load      (state_ff == ST_MIX),
      .color     (color_ff),
      .old_rgb   (old_rgb),
      .alpha     (alpha_ff),
      .mixed_rgb (mixed_rgb)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_written      = rsp_written_ff;
   assign rsp_word_address = rsp_address_ff;
   assign rsp_stored_word  = rsp_word_ff;

   // a dropped transaction reports zero address and word
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_written |-> rsp_word_address == '0 && rsp_stored_word == '0)
      else $error("dropped response carries nonzero fields");

   // the store is only written back for a transaction that hit the frame
   a_wb_hit: assert property (@(posedge clock) disable iff (reset)
      st_wr_en && state_ff != ST_CLEAR |-> hit_ff && state_ff == ST_DONE)
      else $error("store written outside write-back of a hit");

   // an accepted transaction always moves to address computation
   a_accept_addr: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_ADDR)
      else $error("accepted transaction did not start");

   // a new response is loaded only from the write-back step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside write-back");

endmodule
